// File: rtl/json_string_unescaper_core_macros.svh
// ----------------------------------------------------------------------------
// json_string_unescaper_core_macros - assertion helpers
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPER_CORE_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and constants of the JSON string unescaper
// Status codes, escape phases and the byte codes the decoder reacts to.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_UNKNOWN_ESC = 3'd1,
		ST_TRUNCATED   = 3'd2,
		ST_BAD_HEX     = 3'd3,
		ST_BAD_UNIT    = 3'd4,
		ST_BAD_PAIR    = 3'd5
	} status_t;

	// position inside an escape sequence
	typedef enum logic [3:0] {
		PH_TEXT    = 4'd0,
		PH_ESC     = 4'd1,
		PH_HEX1    = 4'd2,
		PH_WAIT_BS = 4'd3,
		PH_WAIT_U  = 4'd4,
		PH_HEX2    = 4'd5
	} phase_t;

	// bytes with meaning after a backslash
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	// control codes the short escapes turn into
	localparam logic [7:0] CC_BS = 8'h08;
	localparam logic [7:0] CC_FF = 8'h0C;
	localparam logic [7:0] CC_LF = 8'h0A;
	localparam logic [7:0] CC_CR = 8'h0D;
	localparam logic [7:0] CC_HT = 8'h09;

	// UTF-16 surrogate ranges
	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	// UTF-8 size limits and lead / continuation marks
	localparam logic [20:0] UTF8_1_LIM = 21'h00080;
	localparam logic [20:0] UTF8_2_LIM = 21'h00800;
	localparam logic [20:0] UTF8_3_LIM = 21'h10000;
	localparam logic [7:0]  LEAD_2     = 8'hC0;
	localparam logic [7:0]  LEAD_3     = 8'hE0;
	localparam logic [7:0]  LEAD_4     = 8'hF0;
	localparam logic [7:0]  CONT_MARK  = 8'h80;

endpackage

`default_nettype wire

// File: rtl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if - stream channels of the JSON string unescaper
// Escaped input bytes and unescaped result words, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// escaped string bytes
interface jsu_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// unescaped result words
interface jsu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic [2:0] status;

	modport source (output valid, output out_byte, output out_last, output status,
		input ready);
	modport sink   (input valid, input out_byte, input out_last, input status,
		output ready);
endinterface

`default_nettype wire

// File: rtl/json_string_unescaper_core.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_core - JSON string body unescaper
// Decodes escapes and \u sequences (with surrogate pairs) into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Each input byte waits in an input register for a free result register and
// is decoded in a single pass into a group of 0 to 5 words (up to four UTF-8
// bytes plus the terminator or error word). While the receiver is ready, the
// group drains at one word per cycle and plain text streams at one byte per
// clock. A byte passes the input and then the result register before its
// first word shows; one that yields k words holds the result register until
// all k drain, and the next group waits. The single-word output port sets the
// rate. On an error a single status word closes the string and the remaining
// bytes up to the one marked last are swallowed.
`default_nettype none

module json_string_unescaper_core
	import jsu_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	jsu_raw_if.sink          raw,
	jsu_text_if.source       text
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decoder state
	phase_t      phase_q;
	logic [15:0] acc_q;
	logic [1:0]  dcnt_q;
	logic [9:0]  hs_q;
	logic        drop_q;

	// result group register
	logic [7:0] grp_byte_q [4];
	logic [2:0] grp_data_q;
	logic [2:0] grp_total_q;
	logic [2:0] grp_idx_q;
	status_t    grp_st_q;

	// next-state and group contents
	phase_t      phase_d;
	logic [15:0] acc_d;
	logic [1:0]  dcnt_d;
	logic [9:0]  hs_d;
	logic        drop_d;
	logic [7:0]  dat [4];
	logic [2:0]  ndat;
	logic        tail;
	status_t     tail_st;
	status_t     err;
	logic        enc;
	logic [20:0] cp;
	logic        hex_ok;
	logic [3:0]  hex_val;

	logic grp_free;
	logic proc;
	logic out_fire;

	// hex digit value
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h41 && b <= 8'h46)
			r = {1'b1, 4'(b - 8'h37)};
		else if (b >= 8'h61 && b <= 8'h66)
			r = {1'b1, 4'(b - 8'h57)};
		return r;
	endfunction

	// handshake
	assign out_fire  = text.valid && text.ready;
	assign grp_free  = (grp_idx_q == grp_total_q) ||
		(text.ready && (3'(grp_idx_q + 3'd1) == grp_total_q));
	assign proc      = valid_s1 && grp_free;
	assign raw.ready = !valid_s1 || proc;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			byte_s1 <= raw.in_byte;
			last_s1 <= raw.in_last;
		end
	end

	assign {hex_ok, hex_val} = hex_digit(byte_s1);

	// decode one byte
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		dcnt_d  = dcnt_q;
		hs_d    = hs_q;
		drop_d  = drop_q;
		for (int i = 0; i < 4; i++) dat[i] = 8'h00;
		ndat    = 3'd0;
		tail    = 1'b0;
		tail_st = ST_OK;
		err     = ST_OK;
		enc     = 1'b0;
		cp      = 21'b0;

		if (drop_q) begin
			if (last_s1) begin
				drop_d  = 1'b0;
				phase_d = PH_TEXT;
				acc_d   = 16'b0;
				dcnt_d  = 2'b0;
				hs_d    = 10'b0;
			end
		end else begin
			case (phase_q)
				PH_ESC: begin
					phase_d = PH_TEXT;
					ndat    = 3'd1;
					case (byte_s1)
						CH_B: dat[0] = CC_BS;
						CH_F: dat[0] = CC_FF;
						CH_N: dat[0] = CC_LF;
						CH_R: dat[0] = CC_CR;
						CH_T: dat[0] = CC_HT;
						CH_QUOTE, CH_BSLASH, CH_SLASH: dat[0] = byte_s1;
						CH_U: begin
							ndat    = 3'd0;
							phase_d = PH_HEX1;
							acc_d   = 16'b0;
							dcnt_d  = 2'b0;
						end
						default: begin
							ndat = 3'd0;
							err  = ST_UNKNOWN_ESC;
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (!hex_ok) begin
						err = ST_BAD_HEX;
					end else begin
						acc_d = {acc_q[11:0], hex_val};
						if (dcnt_q != 2'd3) begin
							dcnt_d = 2'(dcnt_q + 2'd1);
						end else begin
							dcnt_d = 2'd0;
							if (phase_q == PH_HEX1) begin
								if (acc_d == 16'b0 ||
									(acc_d >= LO_SURR_MIN && acc_d <= LO_SURR_MAX)) begin
									err = ST_BAD_UNIT;
								end else if (acc_d >= HI_SURR_MIN && acc_d <= HI_SURR_MAX) begin
									hs_d    = acc_d[9:0];
									phase_d = PH_WAIT_BS;
								end else begin
									cp      = {5'b0, acc_d};
									enc     = 1'b1;
									phase_d = PH_TEXT;
								end
							end else begin
								if (acc_d < LO_SURR_MIN || acc_d > LO_SURR_MAX) begin
									err = ST_BAD_PAIR;
								end else begin
									cp      = SUPP_BASE + {1'b0, hs_q, acc_d[9:0]};
									enc     = 1'b1;
									phase_d = PH_TEXT;
								end
							end
						end
					end
				end
				PH_WAIT_BS: begin
					if (byte_s1 == CH_BSLASH) phase_d = PH_WAIT_U;
					else err = ST_BAD_PAIR;
				end
				PH_WAIT_U: begin
					if (byte_s1 == CH_U) begin
						phase_d = PH_HEX2;
						acc_d   = 16'b0;
						dcnt_d  = 2'b0;
					end else begin
						err = ST_BAD_PAIR;
					end
				end
				default: begin
					phase_d = PH_TEXT;
					if (byte_s1 == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else begin
						dat[0] = byte_s1;
						ndat   = 3'd1;
					end
				end
			endcase

			// UTF-8 encoding of a finished code point
			if (enc) begin
				if (cp < UTF8_1_LIM) begin
					dat[0] = cp[7:0];
					ndat   = 3'd1;
				end else if (cp < UTF8_2_LIM) begin
					dat[0] = LEAD_2 | {3'b0, cp[10:6]};
					dat[1] = CONT_MARK | {2'b0, cp[5:0]};
					ndat   = 3'd2;
				end else if (cp < UTF8_3_LIM) begin
					dat[0] = LEAD_3 | {4'b0, cp[15:12]};
					dat[1] = CONT_MARK | {2'b0, cp[11:6]};
					dat[2] = CONT_MARK | {2'b0, cp[5:0]};
					ndat   = 3'd3;
				end else begin
					dat[0] = LEAD_4 | {5'b0, cp[20:18]};
					dat[1] = CONT_MARK | {2'b0, cp[17:12]};
					dat[2] = CONT_MARK | {2'b0, cp[11:6]};
					dat[3] = CONT_MARK | {2'b0, cp[5:0]};
					ndat   = 3'd4;
				end
			end

			// closing word: error, or end of string
			if (err != ST_OK) begin
				tail    = 1'b1;
				tail_st = err;
				drop_d  = !last_s1;
			end else if (last_s1) begin
				tail    = 1'b1;
				tail_st = (phase_d != PH_TEXT) ? ST_TRUNCATED : ST_OK;
			end
			if (tail) begin
				phase_d = PH_TEXT;
				acc_d   = 16'b0;
				dcnt_d  = 2'b0;
				hs_d    = 10'b0;
			end
		end
	end

	// decoder state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			acc_q   <= 16'b0;
			dcnt_q  <= 2'b0;
			hs_q    <= 10'b0;
			drop_q  <= 1'b0;
		end else if (proc) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			dcnt_q  <= dcnt_d;
			hs_q    <= hs_d;
			drop_q  <= drop_d;
		end
	end

	// result group counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_total_q <= 3'd0;
			grp_idx_q   <= 3'd0;
		end else if (proc) begin
			grp_total_q <= 3'(ndat + {2'b0, tail});
			grp_idx_q   <= 3'd0;
		end else if (out_fire) begin
			grp_idx_q   <= 3'(grp_idx_q + 3'd1);
		end
	end

	// result group payload
	always_ff @(posedge clk) begin
		if (proc) begin
			grp_byte_q <= dat;
			grp_data_q <= ndat;
			grp_st_q   <= tail_st;
		end
	end

	// output word select
	assign text.valid    = (grp_idx_q != grp_total_q);
	assign text.out_last = (grp_idx_q >= grp_data_q);
	assign text.out_byte = text.out_last ? 8'h00 : grp_byte_q[grp_idx_q[1:0]];
	assign text.status   = text.out_last ? grp_st_q : ST_OK;

	`include "json_string_unescaper_core_macros.svh"

	`JSU_ASSERT_NOW(a_status_closes, text.valid && text.status != ST_OK, text.out_last, "error status word without last flag")
	`JSU_ASSERT_NOW(a_last_is_final, text.valid && text.out_last, 3'(grp_idx_q + 3'd1) == grp_total_q, "last word is not the final word of its group")
	`JSU_ASSERT_NEXT(a_s1_holds, valid_s1 && !grp_free, valid_s1 && $stable(byte_s1), "input word lost while result group busy")
	`JSU_ASSERT_NEXT(a_drop_silent, proc && drop_q, grp_total_q == 3'd0, "result produced while dropping a string")

endmodule

`default_nettype wire
